@@ rtl/core/ilp_pkg.sv @@
// Shared types and constants for the integer literal parser.
package ilp_pkg;

	localparam logic [1:0] MODE_ANY      = 2'd0;
	localparam logic [1:0] MODE_UNSIGNED = 2'd1;
	localparam logic [1:0] MODE_SIGNED   = 2'd2;
	localparam logic [1:0] MODE_RESERVED = 2'd3;

	localparam logic [4:0] POS_MAX = 5'd31;

	typedef enum logic [1:0] {
		RADIX_DEC = 2'd0,
		RADIX_HEX = 2'd1,
		RADIX_OCT = 2'd2,
		RADIX_BIN = 2'd3
	} radix_t;

	typedef enum logic [2:0] {
		FORM_START   = 3'd0,
		FORM_MINUS   = 3'd1,
		FORM_ZERO    = 3'd2,
		FORM_NEGZERO = 3'd3,
		FORM_BODY    = 3'd4
	} form_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_DIGIT = 2'd1,
		ST_TOO_MANY  = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0]  ch;
		logic        first_char;
		logic        last_char;
		logic [3:0]  skip_count;
		logic [5:0]  max_bits;
		logic [31:0] offset;
		logic [1:0]  sign_mode;
	} item_t;

	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  status;
	} result_t;

	typedef struct packed {
		logic [3:0]  skip;
		logic [5:0]  width;
		logic [31:0] sub;
		logic [1:0]  mode;
	} settings_t;

	typedef struct packed {
		logic [31:0] acc;
		radix_t      radix;
		logic        neg;
		logic [4:0]  pos;
		status_t     err;
		form_t       form;
	} parse_t;

	typedef struct packed {
		logic [31:0] acc;
		logic        neg;
		form_t       form;
		status_t     err;
		settings_t   set;
	} fin_t;

	localparam parse_t PARSE_CLEAR = '{
		acc:   32'd0,
		radix: RADIX_DEC,
		neg:   1'b0,
		pos:   5'd0,
		err:   ST_OK,
		form:  FORM_START
	};

endpackage

@@ rtl/core/ilp_step.sv @@
// Per-character parse step: skip count, prefix tracking and digit accumulation.
module ilp_step (
	input  logic [7:0]      ch,
	input  logic [3:0]      skip,
	input  ilp_pkg::parse_t cur,
	output ilp_pkg::parse_t nxt
);

	function automatic logic [4:0] digit_of(input logic [7:0] c, input ilp_pkg::radix_t r);
		logic [4:0] d;
		logic       ok;
		d  = 5'd0;
		ok = 1'b0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d  = 5'(c - 8'h30);
			ok = 1'b1;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d  = 5'(c - 8'h41) + 5'd10;
			ok = 1'b1;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d  = 5'(c - 8'h61) + 5'd10;
			ok = 1'b1;
		end
		case (r)
			ilp_pkg::RADIX_HEX: ok = ok;
			ilp_pkg::RADIX_DEC: ok = ok && (d <= 5'd9);
			ilp_pkg::RADIX_OCT: ok = ok && (d <= 5'd7);
			default:            ok = ok && (d <= 5'd1);
		endcase
		return {ok, d[3:0]};
	endfunction

	function automatic ilp_pkg::parse_t body_char(input ilp_pkg::parse_t p, input logic [7:0] c);
		ilp_pkg::parse_t q;
		logic [4:0]      dv;
		logic [31:0]     dx;
		q  = p;
		dv = digit_of(c, p.radix);
		dx = {28'd0, dv[3:0]};
		if (p.err != ilp_pkg::ST_OK) begin
			q = p;
		end else if (p.acc[31]) begin
			q.err = ilp_pkg::ST_TOO_MANY;
		end else if (c == "_") begin
			q = p;
		end else if (!dv[4]) begin
			q.err = ilp_pkg::ST_BAD_DIGIT;
		end else begin
			case (p.radix)
				ilp_pkg::RADIX_HEX: q.acc = (p.acc << 4) + dx;
				ilp_pkg::RADIX_DEC: q.acc = (p.acc << 3) + (p.acc << 1) + dx;
				ilp_pkg::RADIX_OCT: q.acc = (p.acc << 3) + dx;
				default:            q.acc = (p.acc << 1) + dx;
			endcase
		end
		return q;
	endfunction

	ilp_pkg::parse_t txt;

	always_comb begin
		txt = cur;
		case (cur.form)
			ilp_pkg::FORM_START: begin
				if (ch == "-") begin
					txt.neg  = 1'b1;
					txt.form = ilp_pkg::FORM_MINUS;
				end else if (ch == "0") begin
					txt.form = ilp_pkg::FORM_ZERO;
				end else begin
					txt      = body_char(cur, ch);
					txt.form = ilp_pkg::FORM_BODY;
				end
			end
			ilp_pkg::FORM_MINUS: begin
				txt      = body_char(cur, ch);
				txt.form = (ch == "0") ? ilp_pkg::FORM_NEGZERO : ilp_pkg::FORM_BODY;
			end
			ilp_pkg::FORM_ZERO: begin
				if (ch == "x" || ch == "X") begin
					txt.radix = ilp_pkg::RADIX_HEX;
				end else if (ch == "b" || ch == "B") begin
					txt.radix = ilp_pkg::RADIX_BIN;
				end else begin
					txt.radix = ilp_pkg::RADIX_OCT;
					txt       = body_char(txt, ch);
				end
				txt.form = ilp_pkg::FORM_BODY;
			end
			ilp_pkg::FORM_NEGZERO: begin
				txt      = body_char(cur, ch);
				txt.form = ilp_pkg::FORM_BODY;
			end
			default: begin
				txt = body_char(cur, ch);
			end
		endcase
	end

	always_comb begin
		if (cur.pos < {1'b0, skip}) begin
			nxt     = cur;
			nxt.pos = cur.pos + 5'd1;
		end else begin
			nxt = txt;
			if (cur.pos < ilp_pkg::POS_MAX) begin
				nxt.pos = cur.pos + 5'd1;
			end else begin
				nxt.pos = cur.pos;
			end
		end
	end

endmodule

@@ rtl/core/ilp_finish.sv @@
// Final value and status: offset, sign and width range checks, negation.
module ilp_finish (
	input  ilp_pkg::fin_t    fin,
	output ilp_pkg::result_t res
);

	logic [5:0]       mb;
	logic [31:0]      half;
	logic [31:0]      v;
	logic             zero_form;
	logic             uns_m;
	logic             sgn_m;
	logic             wide;
	logic             range_bad;
	ilp_pkg::status_t st;

	always_comb begin
		if (fin.set.width == 6'd0) begin
			mb = 6'd1;
		end else if (fin.set.width > 6'd32) begin
			mb = 6'd32;
		end else begin
			mb = fin.set.width;
		end
		half      = 32'd1 << (mb - 6'd1);
		zero_form = (fin.form == ilp_pkg::FORM_ZERO) || (fin.form == ilp_pkg::FORM_NEGZERO);
		uns_m     = (fin.set.mode == ilp_pkg::MODE_UNSIGNED);
		sgn_m     = (fin.set.mode == ilp_pkg::MODE_SIGNED);
		if (zero_form) begin
			v = 32'd0 - fin.set.sub;
		end else if (uns_m) begin
			v = fin.acc - fin.set.sub;
		end else begin
			v = fin.acc;
		end
		wide      = (v >> mb) != 32'd0;
		range_bad = wide
			|| (!uns_m && (zero_form || fin.neg) && (v > half))
			|| (sgn_m && (zero_form || !fin.neg) && (v >= half));
		if (zero_form) begin
			st = range_bad ? ilp_pkg::ST_RANGE : ilp_pkg::ST_OK;
		end else if (fin.neg && uns_m) begin
			st = ilp_pkg::ST_RANGE;
		end else if (fin.err != ilp_pkg::ST_OK) begin
			st = fin.err;
		end else begin
			st = range_bad ? ilp_pkg::ST_RANGE : ilp_pkg::ST_OK;
		end
		res.status = st;
		if (st != ilp_pkg::ST_OK) begin
			res.value = 32'd0;
		end else if (fin.neg && !zero_form) begin
			res.value = 32'd0 - v;
		end else begin
			res.value = v;
		end
	end

endmodule

@@ rtl/core/integer_literal_parser.sv @@
// Top level of the integer literal parser.
// The finish stage registers the final parse state, the output register its result.
// Throughput: one character per cycle; the input stalls only while a result
// waits in the output register with the finish stage also full.
// Reset: arst_n clears all valid bits, the parse state and the latched settings.
module integer_literal_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  ilp_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output ilp_pkg::result_t result
);

	ilp_pkg::item_t     item_s1;
	logic               valid_s1;
	ilp_pkg::fin_t      fin_s2;
	logic               valid_s2;
	ilp_pkg::result_t   result_q;
	logic               result_valid_q;
	ilp_pkg::parse_t    parse_q;
	ilp_pkg::settings_t set_q;

	ilp_pkg::settings_t set_cur;
	ilp_pkg::parse_t    parse_cur;
	ilp_pkg::parse_t    parse_nxt;
	ilp_pkg::result_t   fin_res;
	logic               out_free;
	logic               s2_free;
	logic               proc;

	assign out_free   = !result_valid_q || result_ready;
	assign s2_free    = !valid_s2 || out_free;
	assign proc       = valid_s1 && (!item_s1.last_char || s2_free);
	assign item_ready = !valid_s1 || proc;

	always_comb begin
		if (item_s1.first_char) begin
			set_cur.skip  = item_s1.skip_count;
			set_cur.width = item_s1.max_bits;
			set_cur.sub   = item_s1.offset;
			set_cur.mode  = (item_s1.sign_mode == ilp_pkg::MODE_RESERVED) ?
				ilp_pkg::MODE_ANY : item_s1.sign_mode;
			parse_cur     = ilp_pkg::PARSE_CLEAR;
		end else begin
			set_cur   = set_q;
			parse_cur = parse_q;
		end
	end

	ilp_step u_step (
		.ch   (item_s1.ch),
		.skip (set_cur.skip),
		.cur  (parse_cur),
		.nxt  (parse_nxt)
	);

	ilp_finish u_finish (
		.fin (fin_s2),
		.res (fin_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			result_valid_q <= 1'b0;
			parse_q        <= ilp_pkg::PARSE_CLEAR;
			set_q          <= '0;
		end else begin
			if (item_valid && item_ready) begin
				valid_s1 <= 1'b1;
			end else if (proc) begin
				valid_s1 <= 1'b0;
			end
			if (proc) begin
				set_q   <= set_cur;
				parse_q <= item_s1.last_char ? ilp_pkg::PARSE_CLEAR : parse_nxt;
			end
			if (proc && item_s1.last_char) begin
				valid_s2 <= 1'b1;
			end else if (out_free) begin
				valid_s2 <= 1'b0;
			end
			if (valid_s2 && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
		if (proc && item_s1.last_char) begin
			fin_s2.acc  <= parse_nxt.acc;
			fin_s2.neg  <= parse_nxt.neg;
			fin_s2.form <= parse_nxt.form;
			fin_s2.err  <= parse_nxt.err;
			fin_s2.set  <= set_cur;
		end
		if (valid_s2 && out_free) begin
			result_q <= fin_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

@@ rtl/core/ilp_checker.sv @@
// Port-level assertions for the integer literal parser, bound to the top level.
module ilp_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_ready,
	input logic             result_valid,
	input logic             result_ready,
	input ilp_pkg::result_t result
);

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped before its transfer");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result))
		else $error("result changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> result_valid && !result_ready)
		else $error("input stalled without a stalled result");

	a_error_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != ilp_pkg::ST_OK |-> result.value == 32'd0)
		else $error("nonzero value with an error status");

endmodule

bind integer_literal_parser ilp_checker u_ilp_checker (.*);
